FILE: sv/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LGE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("property violated");
`define LGE_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define LGE_ASSERT(lbl, clk, rst, prop)
`define LGE_NEVER(lbl, clk, rst, cond)
`endif
`endif

FILE: sv/lge_pkg.sv
// Shared types and constants of the life grid generation engine.
`timescale 1ns / 1ps
package lge_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 64;
  localparam int unsigned MAX_HEIGHT_DEF = 64;

  localparam int unsigned CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_STEP   = 2'd0,
    OP_TOGGLE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic cap;
    logic rd_pt;
    logic pt_eval;
    logic rd_sweep;
    logic win_clr;
    logic flush;
    logic clr;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic in_rng;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/lge_ctrl.sv
// Operation sequencer of the life grid engine.
`timescale 1ns / 1ps
module lge_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lge_pkg::sts_t sts,
  output lge_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_SWEEP = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_FLUSH = 7'b0010000,
    S_PWAIT = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.op) inside
          lge_pkg::OP_STEP: begin
            cmd.win_clr = 1'b1;
            state_next  = S_SWEEP;
          end
          lge_pkg::OP_CLEAR: begin
            cmd.clr    = 1'b1;
            state_next = S_DONE;
          end
          lge_pkg::OP_TOGGLE, lge_pkg::OP_READ: begin
            if (sts.in_rng) begin
              cmd.rd_pt  = 1'b1;
              state_next = S_PWAIT;
            end else begin
              state_next = S_DONE;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SWEEP: begin
        cmd.rd_sweep = 1'b1;
        if (sts.rd_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_FLUSH;
      S_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = S_DONE;
      end
      S_PWAIT: begin
        cmd.pt_eval = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: sv/lge_dp.sv
// Datapath: config registers, cell memory, column window, result register.
`timescale 1ns / 1ps
module lge_dp #(
  parameter int unsigned MAX_WIDTH  = lge_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lge_pkg::MAX_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_addr,
  input  logic [lge_pkg::CFG_W-1:0] cfg_wdata,
  input  logic [1:0]               op,
  input  logic [5:0]               x_pos,
  input  logic [5:0]               y_pos,
  input  lge_pkg::cmd_t            cmd,
  output lge_pkg::sts_t            sts,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic                     cell_alive,
  output logic                     in_range
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT);
  localparam int unsigned AWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AHW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned XE  = (XW > 6) ? XW : 6;
  localparam int unsigned YE  = (YW > 6) ? YW : 6;
  localparam int unsigned CW  = (AWW > lge_pkg::CFG_W) ? AWW : lge_pkg::CFG_W;
  localparam int unsigned CH  = (AHW > lge_pkg::CFG_W) ? AHW : lge_pkg::CFG_W;

  // configuration
  logic [lge_pkg::CFG_W-1:0] grid_width, grid_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= lge_pkg::CFG_RESET;
      grid_height <= lge_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (lge_pkg::reg_idx_t'(cfg_addr))
        lge_pkg::REG_WIDTH:  grid_width  <= cfg_wdata;
        lge_pkg::REG_HEIGHT: grid_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp to 1..max
  logic [CW-1:0] gw_e, aw_c;
  logic [CH-1:0] gh_e, ah_c;
  logic [AWW-1:0] aw;
  logic [AHW-1:0] ah;

  always_comb begin
    gw_e = CW'(grid_width);
    gh_e = CH'(grid_height);
    if (gw_e == '0) aw_c = CW'(1);
    else if (gw_e > CW'(MAX_WIDTH)) aw_c = CW'(MAX_WIDTH);
    else aw_c = gw_e;
    if (gh_e == '0) ah_c = CH'(1);
    else if (gh_e > CH'(MAX_HEIGHT)) ah_c = CH'(MAX_HEIGHT);
    else ah_c = gh_e;
    aw = AWW'(aw_c);
    ah = AHW'(ah_c);
  end

  // captured transaction
  lge_pkg::op_t op_q;
  logic [5:0]   x_q, y_q;
  logic [XE-1:0] x_ext;
  logic [YE-1:0] y_ext;
  logic [XW-1:0] xa;
  logic [YW-1:0] ya;
  logic          in_rng;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_q <= lge_pkg::op_t'(op);
      x_q  <= x_pos;
      y_q  <= y_pos;
    end
  end

  assign x_ext  = XE'(x_q);
  assign y_ext  = YE'(y_q);
  assign xa     = x_ext[XW-1:0];
  assign ya     = y_ext[YW-1:0];
  assign in_rng = (CW'(x_q) < aw_c) && (CH'(y_q) < ah_c);

  // cell memory, valid bit per column stands for the cleared state
  logic [MAX_HEIGHT-1:0] mem [MAX_WIDTH];
  logic [MAX_WIDTH-1:0]  col_vld;
  logic [MAX_HEIGHT-1:0] mem_rd, rcol, wr_data;
  logic                  vld_rd, rd_en, wr_en;
  logic [XW-1:0]         rd_addr, wr_addr;
  logic [XW-1:0]         rc, wc;

  assign rd_en   = cmd.rd_pt | cmd.rd_sweep;
  assign rd_addr = cmd.rd_pt ? xa : rc;
  assign rcol    = vld_rd ? mem_rd : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rd <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_vld <= '0;
      vld_rd  <= 1'b0;
    end else begin
      if (rd_en) begin
        vld_rd <= col_vld[rd_addr];
      end
      if (cmd.clr) begin
        col_vld <= '0;
      end else if (wr_en) begin
        col_vld[wr_addr] <= 1'b1;
      end
    end
  end

  // generation sweep: window of previous and current column
  logic                  rd_vld_q, cur_vld, shift_en, wr_step;
  logic [MAX_HEIGHT-1:0] prev, cur, in_col, hm, pm, cm, nm, new_col, nb;
  logic [MAX_HEIGHT-1:0] pu, pd, cu, cd, nu, nd;
  logic [3:0]            cnt;

  assign shift_en = rd_vld_q | cmd.flush;
  assign in_col   = rd_vld_q ? rcol : '0;
  assign wr_step  = shift_en & cur_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld_q <= 1'b0;
      cur_vld  <= 1'b0;
    end else begin
      rd_vld_q <= cmd.rd_sweep;
      if (cmd.win_clr) cur_vld <= 1'b0;
      else if (shift_en) cur_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_clr) begin
      rc   <= '0;
      wc   <= '0;
      prev <= '0;
      cur  <= '0;
    end else begin
      if (cmd.rd_sweep) rc <= rc + XW'(1);
      if (shift_en) begin
        prev <= cur;
        cur  <= in_col;
      end
      if (wr_step) wc <= wc + XW'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_HEIGHT; i++) begin
      hm[i] = (AHW'(i) < ah);
    end
    pm = prev & hm;
    cm = cur & hm;
    nm = in_col & hm;
    pu = pm << 1;
    pd = pm >> 1;
    cu = cm << 1;
    cd = cm >> 1;
    nu = nm << 1;
    nd = nm >> 1;
    for (int i = 0; i < MAX_HEIGHT; i++) begin
      cnt = 4'(pu[i]) + 4'(pm[i]) + 4'(pd[i]) + 4'(cu[i]) + 4'(cd[i])
          + 4'(nu[i]) + 4'(nm[i]) + 4'(nd[i]);
      nb[i] = (cnt == 4'd3) | (cm[i] & (cnt == 4'd2));
    end
    new_col = (nb & hm) | (cur & ~hm);
  end

  // single-cell access
  logic [MAX_HEIGHT-1:0] tcol;
  logic                  wr_pt, res_alive;

  assign tcol  = (op_q == lge_pkg::OP_TOGGLE) ? (rcol ^ (MAX_HEIGHT'(1) << ya)) : rcol;
  assign wr_pt = cmd.pt_eval & (op_q == lge_pkg::OP_TOGGLE);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      res_alive <= 1'b0;
    end else if (cmd.pt_eval) begin
      res_alive <= tcol[ya];
    end
  end

  assign wr_en   = wr_pt | wr_step;
  assign wr_addr = wr_pt ? xa : wc;
  assign wr_data = wr_pt ? tcol : new_col;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      cell_alive <= res_alive;
      in_range   <= (op_q == lge_pkg::OP_STEP) | (op_q == lge_pkg::OP_CLEAR) | in_rng;
    end
  end

  assign sts.op       = op_q;
  assign sts.in_rng   = in_rng;
  assign sts.rd_last  = (AWW'(rc) == (aw - AWW'(1)));
  assign sts.out_free = ~out_valid | out_ready;

endmodule

FILE: sv/life_grid_generation_engine.sv
// Life grid engine: B3/S23 generations, cell toggle, clear and read.
// Sequence: a step sweeps the active columns, then drains and flushes the window;
//   toggle and read in range first read the addressed column; clear and out-of-range access skip it.
// Throughput: one transaction at a time; the column sweep through the single
//   read port of the cell memory sets the step time (one column per cycle).
// Reset (rst, synchronous): all cells dead, width and height back to 64.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module life_grid_generation_engine #(
  parameter int unsigned MAX_WIDTH  = lge_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lge_pkg::MAX_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration writes
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [lge_pkg::CFG_W-1:0] cfg_wdata,
  // input transaction
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                op,
  input  logic [5:0]                x_pos,
  input  logic [5:0]                y_pos,
  // result transaction
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      cell_alive,
  output logic                      in_range
);

  lge_pkg::cmd_t cmd;
  lge_pkg::sts_t sts;

  // Sequencer: decode, column sweep, single-cell access, result handoff.
  lge_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: memory of columns, three-column window, output register.
  // The result register frees the sequencer while a result waits.
  lge_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .op         (op),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .cell_alive (cell_alive),
    .in_range   (in_range)
  );

  // one transaction in flight
  `LGE_ASSERT(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)
  // single memory read port
  `LGE_NEVER(a_one_read, clk, rst, cmd.rd_pt && cmd.rd_sweep)
  // result only loaded into a free output register
  `LGE_ASSERT(a_load_free, clk, rst, cmd.res_load |-> sts.out_free)
  `LGE_ASSERT(a_load_shows, clk, rst, cmd.res_load |=> out_valid)

endmodule
